[rtl/core/can_serial_host_protocol_engine_assert.svh]
// assertion macros for the host protocol engine
// expects signals named clk and rst_n in the including scope
`ifndef CAN_SERIAL_HOST_PROTOCOL_ENGINE_ASSERT_SVH
`define CAN_SERIAL_HOST_PROTOCOL_ENGINE_ASSERT_SVH

// same-cycle implication
`define CSHPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSHPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cshpe_pkg.sv]
// shared types and constants of the host protocol engine
// no dependencies
package cshpe_pkg;

    localparam int IDX_W  = 5;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    localparam logic [7:0] SYNC_BYTE     = 8'hF1;
    localparam logic [7:0] OP_TIME_SYNC  = 8'h01;
    localparam logic [7:0] OP_BUS_PARAMS = 8'h06;
    localparam logic [7:0] OP_DEV_INFO   = 8'h07;
    localparam logic [7:0] OP_KEEPALIVE  = 8'h09;
    localparam logic [7:0] OP_NUM_BUSES  = 8'h0C;
    localparam logic [7:0] OP_EXT_BUSES  = 8'h0D;
    localparam logic [7:0] FRAME_CMD     = 8'h00;

    localparam logic [15:0] BUILD_NUMBER  = 16'd618;
    localparam logic [7:0]  DEV_INFO_FLAG = 8'h20;
    localparam logic [7:0]  KEEP_HI       = 8'hDE;
    localparam logic [7:0]  KEEP_LO       = 8'hAD;
    localparam logic [7:0]  BUS_COUNT     = 8'h03;
    localparam logic [7:0]  BUS_ENABLED   = 8'h01;
    localparam logic [3:0]  MAX_DLEN      = 4'd8;

    localparam logic [IDX_W-1:0] LEN_TIME   = 5'd6;
    localparam logic [IDX_W-1:0] LEN_PARAMS = 5'd17;
    localparam logic [IDX_W-1:0] LEN_INFO   = 5'd8;
    localparam logic [IDX_W-1:0] LEN_KEEP   = 5'd4;
    localparam logic [IDX_W-1:0] LEN_BUSES  = 5'd3;
    localparam logic [IDX_W-1:0] LEN_EXT    = 5'd17;
    localparam logic [IDX_W-1:0] LEN_FRAME  = 5'd12;

    localparam logic [CFG_W-1:0] CAN0_BAUD_RST = 32'd500000;
    localparam logic [CFG_W-1:0] CAN1_BAUD_RST = 32'd500000;
    localparam logic [CFG_W-1:0] LIN_BAUD_RST  = 32'd19200;

    localparam logic [CIDX_W-1:0] REG_CAN0_BAUD = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CAN1_BAUD = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LIN_BAUD  = 2'd2;

    typedef enum logic [2:0] {
        RUN_NONE,
        RUN_TIME,
        RUN_PARAMS,
        RUN_INFO,
        RUN_KEEP,
        RUN_BUSES,
        RUN_EXT,
        RUN_FRAME
    } run_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic take;
        logic capture;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_run;
        logic is_last;
        logic slot_free;
    } dp_status_t;

endpackage

[rtl/core/cshpe_item_if.sv]
// input channel: one host byte or one received frame per beat
// depends on nothing
interface cshpe_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  host_byte;
    logic [31:0] timestamp_us;
    logic [28:0] frame_id;
    logic        extended_flag;
    logic [3:0]  bus_number;
    logic [3:0]  data_length;
    logic [63:0] frame_data;

    modport source (
        output valid, action, host_byte, timestamp_us, frame_id,
               extended_flag, bus_number, data_length, frame_data,
        input  ready
    );
    modport sink (
        input  valid, action, host_byte, timestamp_us, frame_id,
               extended_flag, bus_number, data_length, frame_data,
        output ready
    );
endinterface

[rtl/core/cshpe_byte_if.sv]
// output channel: one byte toward the host per beat
// depends on nothing
interface cshpe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

[rtl/core/cshpe_ctrl.sv]
// controller: takes an item, then steps the datapath through any reply run
// depends on cshpe_pkg
module cshpe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  cshpe_pkg::dp_status_t status,
    output cshpe_pkg::ctrl_cmd_t  cmd
);

    cshpe_pkg::state_t state_reg;
    cshpe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cshpe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cshpe_pkg::ST_IDLE:
            begin
                if (item_valid && status.has_run)
                begin
                    state_next = cshpe_pkg::ST_SEND;
                end
            end
            cshpe_pkg::ST_SEND:
            begin
                if (status.slot_free && status.is_last)
                begin
                    state_next = cshpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cshpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            cshpe_pkg::ST_IDLE:
            begin
                cmd.take    = 1'b1;
                cmd.capture = item_valid;
            end
            cshpe_pkg::ST_SEND:
            begin
                cmd.load = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/cshpe_dp.sv]
// datapath: item capture, parser flag, baud registers, reply byte select, output register
// depends on cshpe_pkg and both channel interfaces
module cshpe_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    cshpe_item_if.sink                          item_ch,
    cshpe_byte_if.source                        byte_ch,
    input  logic                                cfg_we,
    input  logic [cshpe_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [cshpe_pkg::CFG_W-1:0]         cfg_data,
    input  cshpe_pkg::ctrl_cmd_t                cmd,
    output cshpe_pkg::dp_status_t               status
);

    localparam int IW = cshpe_pkg::IDX_W;

    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            2'd2:    b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

    logic [cshpe_pkg::CFG_W-1:0] can0_baud_reg;
    logic [cshpe_pkg::CFG_W-1:0] can1_baud_reg;
    logic [cshpe_pkg::CFG_W-1:0] lin_baud_reg;
    logic                        armed_reg;
    logic                        armed_next;

    cshpe_pkg::run_kind_t kind_reg;
    cshpe_pkg::run_kind_t dec_kind;
    logic [IW-1:0]        len_reg;
    logic [IW-1:0]        dec_len;
    logic [IW-1:0]        idx_reg;
    logic [31:0]          ts_reg;
    logic [31:0]          id_reg;
    logic [7:0]           lenbyte_reg;
    logic [3:0]           dlen_reg;
    logic [63:0]          data_reg;
    logic [3:0]           dlen_sat;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;
    logic [7:0]           gen_byte;

    logic [IW-1:0]        off2;
    logic [IW-1:0]        off3;
    logic [IW-1:0]        off6;
    logic [IW-1:0]        off8;
    logic [IW-1:0]        off11;
    logic [IW-1:0]        off13;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can0_baud_reg <= cshpe_pkg::CAN0_BAUD_RST;
            can1_baud_reg <= cshpe_pkg::CAN1_BAUD_RST;
            lin_baud_reg  <= cshpe_pkg::LIN_BAUD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cshpe_pkg::REG_CAN0_BAUD: can0_baud_reg <= cfg_data;
                cshpe_pkg::REG_CAN1_BAUD: can1_baud_reg <= cfg_data;
                cshpe_pkg::REG_LIN_BAUD:  lin_baud_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign dlen_sat = (item_ch.data_length > cshpe_pkg::MAX_DLEN) ? cshpe_pkg::MAX_DLEN
                                                                  : item_ch.data_length;

    // reply decode of the item on the input channel
    always_comb
    begin
        dec_kind = cshpe_pkg::RUN_NONE;
        dec_len  = '0;
        if (item_ch.action)
        begin
            dec_kind = cshpe_pkg::RUN_FRAME;
            dec_len  = cshpe_pkg::LEN_FRAME + {1'b0, dlen_sat};
        end
        else if (armed_reg)
        begin
            unique case (item_ch.host_byte)
                cshpe_pkg::OP_TIME_SYNC:
                begin
                    dec_kind = cshpe_pkg::RUN_TIME;
                    dec_len  = cshpe_pkg::LEN_TIME;
                end
                cshpe_pkg::OP_BUS_PARAMS:
                begin
                    dec_kind = cshpe_pkg::RUN_PARAMS;
                    dec_len  = cshpe_pkg::LEN_PARAMS;
                end
                cshpe_pkg::OP_DEV_INFO:
                begin
                    dec_kind = cshpe_pkg::RUN_INFO;
                    dec_len  = cshpe_pkg::LEN_INFO;
                end
                cshpe_pkg::OP_KEEPALIVE:
                begin
                    dec_kind = cshpe_pkg::RUN_KEEP;
                    dec_len  = cshpe_pkg::LEN_KEEP;
                end
                cshpe_pkg::OP_NUM_BUSES:
                begin
                    dec_kind = cshpe_pkg::RUN_BUSES;
                    dec_len  = cshpe_pkg::LEN_BUSES;
                end
                cshpe_pkg::OP_EXT_BUSES:
                begin
                    dec_kind = cshpe_pkg::RUN_EXT;
                    dec_len  = cshpe_pkg::LEN_EXT;
                end
                default:
                begin
                    dec_kind = cshpe_pkg::RUN_NONE;
                    dec_len  = '0;
                end
            endcase
        end
    end

    // frames leave the parser as it is; any host byte while armed disarms
    always_comb
    begin
        armed_next = armed_reg;
        if (cmd.capture && !item_ch.action)
        begin
            armed_next = !armed_reg && (item_ch.host_byte == cshpe_pkg::SYNC_BYTE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= cshpe_pkg::RUN_NONE;
            len_reg  <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.capture)
        begin
            kind_reg <= dec_kind;
            len_reg  <= dec_len;
            idx_reg  <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ts_reg      <= item_ch.timestamp_us;
            id_reg      <= {item_ch.extended_flag, 2'b00, item_ch.frame_id};
            lenbyte_reg <= {item_ch.bus_number, dlen_sat};
            dlen_reg    <= dlen_sat;
            data_reg    <= item_ch.frame_data;
        end
    end

    assign off2  = idx_reg - 5'd2;
    assign off3  = idx_reg - 5'd3;
    assign off6  = idx_reg - 5'd6;
    assign off8  = idx_reg - 5'd8;
    assign off11 = idx_reg - 5'd11;
    assign off13 = idx_reg - 5'd13;

    // byte at position idx_reg of the current run
    always_comb
    begin
        gen_byte = 8'h00;
        case (kind_reg)
            cshpe_pkg::RUN_TIME:
            begin
                case (idx_reg) inside
                    5'd0:         gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:         gen_byte = cshpe_pkg::OP_TIME_SYNC;
                    [5'd2:5'd5]:  gen_byte = word_byte(ts_reg, off2[1:0]);
                    default:      gen_byte = 8'h00;
                endcase
            end
            cshpe_pkg::RUN_PARAMS:
            begin
                case (idx_reg) inside
                    5'd0:                gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:                gen_byte = cshpe_pkg::OP_BUS_PARAMS;
                    5'd2, 5'd7, 5'd12:   gen_byte = cshpe_pkg::BUS_ENABLED;
                    [5'd3:5'd6]:         gen_byte = word_byte(can0_baud_reg, off3[1:0]);
                    [5'd8:5'd11]:        gen_byte = word_byte(can1_baud_reg, off8[1:0]);
                    [5'd13:5'd16]:       gen_byte = word_byte(lin_baud_reg, off13[1:0]);
                    default:             gen_byte = 8'h00;
                endcase
            end
            cshpe_pkg::RUN_INFO:
            begin
                case (idx_reg)
                    5'd0:    gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:    gen_byte = cshpe_pkg::OP_DEV_INFO;
                    5'd2:    gen_byte = cshpe_pkg::BUILD_NUMBER[7:0];
                    5'd3:    gen_byte = cshpe_pkg::BUILD_NUMBER[15:8];
                    5'd4:    gen_byte = cshpe_pkg::DEV_INFO_FLAG;
                    default: gen_byte = 8'h00;
                endcase
            end
            cshpe_pkg::RUN_KEEP:
            begin
                case (idx_reg)
                    5'd0:    gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:    gen_byte = cshpe_pkg::OP_KEEPALIVE;
                    5'd2:    gen_byte = cshpe_pkg::KEEP_HI;
                    default: gen_byte = cshpe_pkg::KEEP_LO;
                endcase
            end
            cshpe_pkg::RUN_BUSES:
            begin
                case (idx_reg)
                    5'd0:    gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:    gen_byte = cshpe_pkg::OP_NUM_BUSES;
                    default: gen_byte = cshpe_pkg::BUS_COUNT;
                endcase
            end
            cshpe_pkg::RUN_EXT:
            begin
                case (idx_reg)
                    5'd0:    gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:    gen_byte = cshpe_pkg::OP_EXT_BUSES;
                    default: gen_byte = 8'h00;
                endcase
            end
            cshpe_pkg::RUN_FRAME:
            begin
                case (idx_reg) inside
                    5'd0:        gen_byte = cshpe_pkg::SYNC_BYTE;
                    5'd1:        gen_byte = cshpe_pkg::FRAME_CMD;
                    [5'd2:5'd5]: gen_byte = word_byte(ts_reg, off2[1:0]);
                    [5'd6:5'd9]: gen_byte = word_byte(id_reg, off6[1:0]);
                    5'd10:       gen_byte = lenbyte_reg;
                    default:
                    begin
                        // data bytes, then the trailing zero
                        if (off11 < {1'b0, dlen_reg})
                        begin
                            gen_byte = data_reg[{off11[2:0], 3'b000} +: 8];
                        end
                        else
                        begin
                            gen_byte = 8'h00;
                        end
                    end
                endcase
            end
            default:
            begin
                gen_byte = 8'h00;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (byte_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg <= gen_byte;
            out_last_reg <= status.is_last;
        end
    end

    assign status.has_run   = (dec_kind != cshpe_pkg::RUN_NONE);
    assign status.is_last   = (idx_reg == len_reg - 1'b1);
    assign status.slot_free = !out_valid_reg || byte_ch.ready;

    assign item_ch.ready     = cmd.take;
    assign byte_ch.valid     = out_valid_reg;
    assign byte_ch.out_byte  = out_byte_reg;
    assign byte_ch.last_byte = out_last_reg;

endmodule

[rtl/core/can_serial_host_protocol_engine.sv]
// Device side of a CAN-to-serial host protocol.
// item_ch takes one beat per input: a host byte (action 0) or a CAN frame to report
// (action 1). byte_ch gives the reply as a run of byte beats, last_byte high on the
// final beat of each run. cfg_we/cfg_index/cfg_data write the three baud registers
// (0: can0, 1: can1, 2: lin) used in the bus parameter reply.
// An accepted item with a reply moves the controller to its send state, which loads
// the reply beats into the output register. Throughput: one byte per cycle while
// byte_ch.ready is high; an item with a run of n bytes (3 to 20) keeps item_ch.ready
// low until its last byte is loaded. Host bytes with no reply are taken every cycle
// while the controller is idle. The last beat of a run may still wait in the output
// register while the next item is accepted.
// When byte_ch.ready is low the output register holds its beat and the run pauses.
// Reset clears the parser (sync byte awaited), empties the output register and
// loads the baud registers with 500000, 500000 and 19200.
// Depends on cshpe_pkg, the channel interfaces, cshpe_ctrl and cshpe_dp.
`include "can_serial_host_protocol_engine_assert.svh"

module can_serial_host_protocol_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    cshpe_item_if.sink                   item_ch,
    cshpe_byte_if.source                 byte_ch,
    input  logic                         cfg_we,
    input  logic [cshpe_pkg::CIDX_W-1:0] cfg_index,
    input  logic [cshpe_pkg::CFG_W-1:0]  cfg_data
);

    cshpe_pkg::ctrl_cmd_t  cmd;
    cshpe_pkg::dp_status_t status;

    cshpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .status     (status),
        .cmd        (cmd)
    );

    cshpe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .byte_ch   (byte_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    `CSHPE_ASSERT_NOW(a_load_slot_free, cmd.load, status.slot_free, "beat overwritten in output register")
    `CSHPE_ASSERT_NEXT(a_last_returns_idle, cmd.load && status.is_last, cmd.take, "controller stuck after last beat")
    `CSHPE_ASSERT_NOW(a_no_load_while_taking, cmd.take, !cmd.load, "beat loaded while taking items")
    `CSHPE_ASSERT_NEXT(a_load_shows_beat, cmd.load, byte_ch.valid, "loaded beat not presented")

endmodule
